FILE: rtl/core/mpmc_pkg.sv
// Shared types, constants and helpers for the multi-pattern match counter.
// No dependencies; mpmc_front, mpmc_engine and the top level import this package.
package mpmc_pkg;

    localparam int NODES       = 4096;
    localparam int NODE_W      = 12;
    localparam int USED_W      = 13;
    localparam int PATTERNS    = 1023;
    localparam int PID_W       = 10;
    localparam int ALPHABET    = 27;
    localparam int CLS_W       = 5;
    localparam int CHILD_DEPTH = NODES * ALPHABET;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int COUNT_W     = 24;
    localparam int OCC_DEPTH   = PATTERNS + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_BUILD  = 3'd1;
    localparam logic [2:0] OP_SCAN   = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_LINKS = 2'd2;
    localparam logic [1:0] ST_BAD_ID   = 2'd3;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [7:0]       symbol;
        logic             pattern_end;
        logic [PID_W-1:0] pattern_id;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PID_W-1:0]   pattern_id_res;
        logic [COUNT_W-1:0] count;
    } result_t;

    // classified command handed from front to engine
    typedef struct packed {
        logic [2:0]       op;
        logic [CLS_W-1:0] cls;
        logic             pend;
        logic [PID_W-1:0] pid;
        logic             bad_id;
    } cmd_t;

    function automatic logic [CLS_W-1:0] sym_class(input logic [7:0] sym);
        logic [7:0] d;
        d = sym - CHAR_A;
        if (sym >= CHAR_A && sym <= CHAR_Z)
            return d[CLS_W-1:0];
        return CLS_W'(ALPHABET - 1);
    endfunction

endpackage

FILE: rtl/core/mpmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/mpmc_front.sv
// Front end: two-entry command queue that accepts items and classifies them.
// Depends on mpmc_pkg.
module mpmc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mpmc_pkg::item_t item,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output mpmc_pkg::cmd_t  cmd
);
    import mpmc_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls_cmd;
    logic       do_push, do_pop;

    always_comb
    begin
        cls_cmd.op     = item.opcode;
        cls_cmd.cls    = sym_class(item.symbol);
        cls_cmd.pend   = item.pattern_end;
        cls_cmd.pid    = item.pattern_id;
        cls_cmd.bad_id = (item.pattern_id == '0) ||
                         ({1'b0, item.pattern_id} > (PID_W+1)'(PATTERNS));
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign wp_next   = wp_reg ^ do_push;
    assign rp_next   = rp_reg ^ do_pop;
    assign cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= cls_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: rtl/core/mpmc_engine.sv
// Back end: sequencer that runs insert, build, scan, read and clear on the
// trie memories. Depends on mpmc_pkg and mpmc_ram.
module mpmc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  mpmc_pkg::cmd_t    cmd,
    output logic              res_valid,
    input  logic              res_take,
    output mpmc_pkg::result_t res
);
    import mpmc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLR   = 5'd1;
    localparam logic [4:0] S_INS   = 5'd2;
    localparam logic [4:0] S_BPOP  = 5'd3;
    localparam logic [4:0] S_BU    = 5'd4;
    localparam logic [4:0] S_BV    = 5'd5;
    localparam logic [4:0] S_BF1   = 5'd6;
    localparam logic [4:0] S_BF2   = 5'd7;
    localparam logic [4:0] S_BNX   = 5'd8;
    localparam logic [4:0] S_SCH   = 5'd9;
    localparam logic [4:0] S_SFL   = 5'd10;
    localparam logic [4:0] S_ST    = 5'd11;
    localparam logic [4:0] S_STG   = 5'd12;
    localparam logic [4:0] S_SOC   = 5'd13;
    localparam logic [4:0] S_RD    = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;

    localparam int NAW = $clog2(NODES);
    localparam int OAW = $clog2(OCC_DEPTH);

    logic [4:0]          state_reg, state_next;
    logic [CHILD_AW-1:0] clr_reg, clr_next;
    logic                reply_reg, reply_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   scan_reg, scan_next;
    logic                built_reg, built_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CHILD_AW-1:0] addr_reg, addr_next;
    logic [NODE_W-1:0]   u_reg, u_next, v_reg, v_next, f_reg, f_next, t_reg, t_next;
    logic [CLS_W-1:0]    c_reg, c_next;
    logic [USED_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [PID_W-1:0]    tag_reg, tag_next;
    result_t             res_reg, res_next;

    // memory ports
    logic [NODE_W-1:0]   ch_node;
    logic [CLS_W-1:0]    ch_cls;
    logic [CHILD_AW-1:0] ch_raddr, ch_waddr;
    logic                ch_we;
    logic [NODE_W-1:0]   ch_wdata, ch_rdata;
    logic                fl_we;
    logic [NAW-1:0]      fl_waddr, fl_raddr;
    logic [NODE_W-1:0]   fl_wdata, fl_rdata;
    logic                np_we;
    logic [NAW-1:0]      np_waddr, np_raddr;
    logic [PID_W-1:0]    np_wdata, np_rdata;
    logic                oc_we;
    logic [OAW-1:0]      oc_waddr, oc_raddr;
    logic [COUNT_W-1:0]  oc_wdata, oc_rdata;
    logic                wq_we;
    logic [NAW-1:0]      wq_waddr, wq_raddr;
    logic [NODE_W-1:0]   wq_wdata, wq_rdata;

    logic                push_en;
    logic [NODE_W-1:0]   push_node;
    logic [NODE_W-1:0]   new_node;

    assign ch_raddr  = CHILD_AW'(ch_node) * CHILD_AW'(ALPHABET) + CHILD_AW'(ch_cls);
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign new_node  = used_reg[NODE_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        reply_next  = reply_reg;
        used_next   = used_reg;
        cursor_next = cursor_reg;
        scan_next   = scan_reg;
        built_next  = built_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        f_next      = f_reg;
        t_next      = t_reg;
        c_next      = c_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        tag_next    = tag_reg;
        res_next    = res_reg;

        ch_node  = u_reg;
        ch_cls   = c_reg;
        ch_we    = 1'b0;
        ch_waddr = addr_reg;
        ch_wdata = '0;
        fl_we    = 1'b0;
        fl_waddr = '0;
        fl_wdata = '0;
        fl_raddr = u_reg;
        np_we    = 1'b0;
        np_waddr = '0;
        np_wdata = '0;
        np_raddr = t_reg;
        oc_we    = 1'b0;
        oc_waddr = tag_reg;
        oc_wdata = '0;
        oc_raddr = tag_reg;
        wq_raddr = head_reg[NAW-1:0];
        push_en   = 1'b0;
        push_node = v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            built_next = 1'b0;
                            if (cmd.pend && cmd.bad_id)
                            begin
                                res_next.status = ST_BAD_ID;
                                cursor_next     = '0;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ch_node    = cursor_reg;
                                ch_cls     = cmd.cls;
                                addr_next  = ch_raddr;
                                state_next = S_INS;
                            end
                        end
                        OP_BUILD:
                        begin
                            fl_we      = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            push_en    = 1'b1;
                            push_node  = '0;
                            state_next = S_BPOP;
                        end
                        OP_SCAN:
                        begin
                            if (!built_reg)
                            begin
                                res_next.status = ST_NO_LINKS;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ch_node    = scan_reg;
                                ch_cls     = cmd.cls;
                                f_next     = scan_reg;
                                state_next = S_SCH;
                            end
                        end
                        OP_READ:
                        begin
                            res_next.pattern_id_res = cmd.pid;
                            if (cmd.bad_id)
                            begin
                                res_next.status = ST_BAD_ID;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                oc_raddr   = OAW'(cmd.pid);
                                state_next = S_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            reply_next = 1'b1;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                ch_we    = 1'b1;
                ch_waddr = clr_reg;
                np_we    = (clr_reg < CHILD_AW'(NODES));
                np_waddr = clr_reg[NAW-1:0];
                oc_we    = (clr_reg < CHILD_AW'(OCC_DEPTH));
                oc_waddr = clr_reg[OAW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CHILD_AW'(CHILD_DEPTH - 1))
                begin
                    used_next   = USED_W'(1);
                    cursor_next = '0;
                    scan_next   = '0;
                    built_next  = 1'b0;
                    reply_next  = 1'b0;
                    state_next  = reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_INS:
            begin
                state_next = S_DONE;
                if (ch_rdata == '0 && used_reg >= USED_W'(NODES))
                begin
                    res_next.status = ST_FULL;
                    cursor_next     = '0;
                end
                else
                begin
                    if (ch_rdata == '0)
                    begin
                        ch_we     = 1'b1;
                        ch_wdata  = new_node;
                        used_next = used_reg + 1'b1;
                        v_next    = new_node;
                    end
                    else
                    begin
                        v_next = ch_rdata;
                    end
                    if (cmd_reg.pend)
                    begin
                        np_we       = 1'b1;
                        np_waddr    = (ch_rdata == '0) ? new_node : ch_rdata;
                        np_wdata    = cmd_reg.pid;
                        cursor_next = '0;
                    end
                    else
                    begin
                        cursor_next = (ch_rdata == '0) ? new_node : ch_rdata;
                    end
                end
            end
            S_BPOP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                    scan_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_BU;
                end
            end
            S_BU:
            begin
                u_next     = wq_rdata;
                c_next     = '0;
                ch_node    = wq_rdata;
                ch_cls     = '0;
                state_next = S_BV;
            end
            S_BV:
            begin
                v_next = ch_rdata;
                if (ch_rdata == '0)
                begin
                    state_next = S_BNX;
                end
                else if (u_reg == '0)
                begin
                    // depth-one nodes fail to the root
                    fl_we      = 1'b1;
                    fl_waddr   = ch_rdata;
                    push_en    = 1'b1;
                    push_node  = ch_rdata;
                    state_next = S_BNX;
                end
                else
                begin
                    fl_raddr   = u_reg;
                    state_next = S_BF1;
                end
            end
            S_BF1:
            begin
                f_next     = fl_rdata;
                ch_node    = fl_rdata;
                state_next = S_BF2;
            end
            S_BF2:
            begin
                if (ch_rdata != '0 || f_reg == '0)
                begin
                    fl_we      = 1'b1;
                    fl_waddr   = v_reg;
                    fl_wdata   = ch_rdata;
                    push_en    = 1'b1;
                    state_next = S_BNX;
                end
                else
                begin
                    fl_raddr   = f_reg;
                    state_next = S_BF1;
                end
            end
            S_BNX:
            begin
                if (c_reg == CLS_W'(ALPHABET - 1))
                begin
                    state_next = S_BPOP;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    ch_cls     = c_reg + 1'b1;
                    state_next = S_BV;
                end
            end
            S_SCH:
            begin
                if (ch_rdata != '0 || f_reg == '0)
                begin
                    scan_next  = ch_rdata;
                    t_next     = ch_rdata;
                    state_next = S_ST;
                end
                else
                begin
                    fl_raddr   = f_reg;
                    state_next = S_SFL;
                end
            end
            S_SFL:
            begin
                f_next     = fl_rdata;
                ch_node    = fl_rdata;
                ch_cls     = cmd_reg.cls;
                state_next = S_SCH;
            end
            S_ST:
            begin
                if (t_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    np_raddr   = t_reg;
                    fl_raddr   = t_reg;
                    state_next = S_STG;
                end
            end
            S_STG:
            begin
                t_next = fl_rdata;
                if (np_rdata != '0)
                begin
                    tag_next = np_rdata;
                    oc_raddr = OAW'(np_rdata);
                    if (res_reg.count != COUNT_MAX)
                    begin
                        res_next.count = res_reg.count + 1'b1;
                    end
                    state_next = S_SOC;
                end
                else
                begin
                    state_next = S_ST;
                end
            end
            S_SOC:
            begin
                oc_we      = 1'b1;
                oc_wdata   = (oc_rdata == COUNT_MAX) ? oc_rdata : oc_rdata + 1'b1;
                state_next = S_ST;
            end
            S_RD:
            begin
                res_next.count = oc_rdata;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a build restarts the walk queue at slot zero
        wq_we    = push_en && (tail_next < USED_W'(NODES));
        wq_waddr = tail_next[NAW-1:0];
        wq_wdata = push_node;
        if (wq_we)
        begin
            tail_next = tail_next + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        addr_reg <= addr_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        f_reg    <= f_next;
        t_reg    <= t_next;
        c_reg    <= c_next;
        tag_reg  <= tag_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            reply_reg  <= 1'b0;
            used_reg   <= USED_W'(1);
            cursor_reg <= '0;
            scan_reg   <= '0;
            built_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            reply_reg  <= reply_next;
            used_reg   <= used_next;
            cursor_reg <= cursor_next;
            scan_reg   <= scan_next;
            built_reg  <= built_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
        .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );
    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fail (
        .clk, .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );
    mpmc_ram #(.WIDTH(PID_W), .DEPTH(NODES)) u_npat (
        .clk, .we(np_we), .waddr(np_waddr), .wdata(np_wdata),
        .raddr(np_raddr), .rdata(np_rdata)
    );
    mpmc_ram #(.WIDTH(COUNT_W), .DEPTH(OCC_DEPTH)) u_occ (
        .clk, .we(oc_we), .waddr(oc_waddr), .wdata(oc_wdata),
        .raddr(oc_raddr), .rdata(oc_rdata)
    );
    mpmc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_walk (
        .clk, .we(wq_we), .waddr(wq_waddr), .wdata(wq_wdata),
        .raddr(wq_raddr), .rdata(wq_rdata)
    );

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) && (used_reg <= USED_W'(NODES)))
        else $error("node count out of range");
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("walk queue head passed tail");
    a_scan_built: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && cmd_reg.op == OP_SCAN && res_reg.status == ST_OK) |-> built_reg)
        else $error("scan matched without failure links");
    a_clear_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && state_next != S_CLR) |=> (used_reg == USED_W'(1) && !built_reg))
        else $error("clear sweep left state behind");
endmodule

FILE: rtl/core/multi_pattern_match_counter.sv
// Top level of the Aho-Corasick multi-pattern match counter: command queue,
// sequencer and two-entry result queue. Depends on mpmc_pkg and submodules.
//
//  channel   handshake            payload
//  item      push / full          item   (opcode, symbol, pattern_end, pattern_id)
//  result    pop / empty          result (status, pattern_id_res, count)
//
// Insert, read, scan and build run through the sequencer states, bound by the
// single read port of each trie memory; a scan also follows failure hops and
// visits output nodes, and build visits each node and child slot in turn.
// After reset, and on clear, a sweep of all NODES*ALPHABET slots (110592) zeroes
// the child table; no item is taken meanwhile, though the input queue fills.
// Results wait in a two-entry queue; a full queue stalls the sequencer.
module multi_pattern_match_counter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mpmc_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output mpmc_pkg::result_t result
);
    import mpmc_pkg::*;

    logic       cmd_valid, cmd_pop;
    cmd_t       cmd;
    logic       res_valid, res_take;
    result_t    res;
    result_t    oq_reg [2];
    logic       owp_reg, orp_reg;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       do_pop;

    mpmc_front u_front (
        .clk, .rst_n, .push, .full, .item,
        .cmd_valid, .cmd_pop, .cmd
    );

    mpmc_engine u_engine (
        .clk, .rst_n, .cmd_valid, .cmd_pop, .cmd,
        .res_valid, .res_take, .res
    );

    assign res_take  = res_valid && (ocnt_reg != 2'd2);
    assign empty     = (ocnt_reg == 2'd0);
    assign do_pop    = pop && !empty;
    assign result    = oq_reg[orp_reg];
    assign ocnt_next = ocnt_reg + 2'(res_take) - 2'(do_pop);

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            oq_reg[owp_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            owp_reg  <= owp_reg ^ res_take;
            orp_reg  <= orp_reg ^ do_pop;
            ocnt_reg <= ocnt_next;
        end
    end
endmodule
